// ===== sv/dbrm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbrm_pkg
// Shared types and constants for the deadband point runtime meter.
// ----------------------------------------------------------------------------
package dbrm_pkg;

   // Item commands.
   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_SAMPLE  = 3'd1,
      CMD_PAIR    = 3'd2,
      CMD_POLL    = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   // Point kinds.
   localparam logic [1:0] KIND_INPUT   = 2'd0;
   localparam logic [1:0] KIND_HOLDING = 2'd1;
   localparam logic [1:0] KIND_OUTPUT  = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_IO_KIND     = 3'd0;
   localparam logic [2:0] CSR_MANUAL_MODE = 3'd1;
   localparam logic [2:0] CSR_DEADBAND    = 3'd2;
   localparam logic [2:0] CSR_OUT_INTERVAL = 3'd3;

   // Register reset values.
   localparam logic [1:0]  IO_KIND_RESET      = KIND_HOLDING;
   localparam logic [30:0] DEADBAND_RESET     = 31'd7;
   localparam logic [15:0] OUT_INTERVAL_RESET = 16'd1000;

   // Run timers keep whole seconds and a millisecond remainder. A millisecond
   // count that saturates at 2^32-1 is 4294967 seconds and 295 ms.
   localparam logic [9:0]  MS_LAST   = 10'd999;
   localparam logic [22:0] SAT_SEC   = 23'd4294967;
   localparam logic [9:0]  SAT_MS    = 10'd295;

   typedef struct packed {
      logic restart;
      logic tick;
   } timer_ctrl_type;

endpackage
`default_nettype wire

// ===== sv/dbrm_run_timer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbrm_run_timer
// Saturating millisecond timer kept as whole seconds plus a remainder.
// ----------------------------------------------------------------------------
module dbrm_run_timer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dbrm_pkg::timer_ctrl_type ctrl,
   output logic [22:0]                  seconds
);

   logic [22:0] sec_ff, sec_in;
   logic [9:0]  ms_ff, ms_in;
   logic        saturated;

   assign saturated = (sec_ff == dbrm_pkg::SAT_SEC) && (ms_ff == dbrm_pkg::SAT_MS);

   always_comb begin
      sec_in = sec_ff;
      ms_in  = ms_ff;
      if (ctrl.restart) begin
         sec_in = '0;
         ms_in  = '0;
      end else if (ctrl.tick && !saturated) begin
         if (ms_ff == dbrm_pkg::MS_LAST) begin
            ms_in  = '0;
            sec_in = sec_ff + 23'd1;
         end else begin
            ms_in = ms_ff + 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff <= '0;
         ms_ff  <= '0;
      end else begin
         sec_ff <= sec_in;
         ms_ff  <= ms_in;
      end
   end

   assign seconds = sec_ff;

endmodule
`default_nettype wire

// ===== sv/deadband_point_runtime_meter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deadband_point_runtime_meter_top
// A request's result is registered and valid in the cycle after it is accepted.
// Throughput: one request per cycle while results are taken as they appear;
// a request waits only while the previous result is stalled by the receiver.
// Reset (synchronous, active high) clears all values, flags and timers and
// loads the register defaults: holding point, deadband 7, interval 1000 ms.
// ----------------------------------------------------------------------------
module deadband_point_runtime_meter_top #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Request channel.
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_cmd,
   input  wire logic signed [31:0] req_value_in,
   input  wire logic signed [31:0] req_value_out,
   // Result channel.
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_measured_value,
   output logic signed [31:0]      rsp_command_value,
   output logic [22:0]             rsp_on_seconds,
   output logic [22:0]             rsp_off_seconds,
   output logic [31:0]             rsp_runtime_seconds,
   output logic                    rsp_changed,
   output logic                    rsp_initialized,
   output logic                    rsp_output_due,
   // Configuration write port.
   input  wire logic               csr_write_en,
   input  wire logic [2:0]         csr_index,
   input  wire logic [30:0]        csr_write_data
);

   // The on threshold is 0.9999 rounded up to the fixed-point grid, so that
   // an integer magnitude at or above it is exactly a value of at least 0.9999.
   localparam logic [32:0] ON_THRESH =
      33'(((64'd9999 << FRAC_BITS) + 64'd9999) / 64'd10000);

   // Magnitude of a signed 32-bit value, formed at 33 bits so -2^31 is exact.
   function automatic logic is_on(input logic [31:0] v);
      logic [32:0] ext;
      logic [32:0] m;
      ext = {v[31], v};
      m   = v[31] ? (33'd0 - ext) : ext;
      return m >= ON_THRESH;
   endfunction

   // True when two values differ by less than the deadband.
   function automatic logic within_band(input logic [31:0] a, input logic [31:0] b,
                                        input logic [30:0] band);
      logic [32:0] diff;
      logic [32:0] m;
      diff = {a[31], a} - {b[31], b};
      m    = diff[32] ? (33'd0 - diff) : diff;
      return m < {2'b00, band};
   endfunction

   // Configuration registers.
   logic [1:0]  io_kind_ff, io_kind_in;
   logic        manual_ff, manual_in;
   logic [30:0] deadband_ff, deadband_in;
   logic [15:0] interval_ff, interval_in;

   // Point state.
   logic [31:0] measured_ff, measured_in;
   logic [31:0] commanded_ff, commanded_in;
   logic        init_ff, init_in;
   logic        changed_ff, changed_in;
   logic [15:0] out_ms_ff, out_ms_in;
   logic [31:0] run_ff, run_in;

   // Result channel control.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        due_ff, due_in;

   logic                     accept;
   dbrm_pkg::cmd_type        cmd;
   dbrm_pkg::timer_ctrl_type on_ctrl, off_ctrl;
   logic [22:0]              on_sec, off_sec;
   logic [32:0]              run_sum;
   logic [32:0]              rt_sum;
   logic                     now_on;

   // A new request is taken whenever the result slot is empty or being
   // emptied in this same cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cmd       = dbrm_pkg::cmd_type'(req_cmd);

   // Whole seconds banked on a falling edge, saturating at 2^32-1.
   assign run_sum = {1'b0, run_ff} + {10'd0, on_sec};

   always_comb begin
      io_kind_in   = io_kind_ff;
      manual_in    = manual_ff;
      deadband_in  = deadband_ff;
      interval_in  = interval_ff;
      measured_in  = measured_ff;
      commanded_in = commanded_ff;
      init_in      = init_ff;
      changed_in   = changed_ff;
      out_ms_in    = out_ms_ff;
      run_in       = run_ff;
      due_in       = due_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      on_ctrl      = '0;
      off_ctrl     = '0;

      if (accept) begin
         rsp_valid_in = 1'b1;
         due_in       = 1'b0;
         case (cmd)
            dbrm_pkg::CMD_TICK: begin
               on_ctrl.tick  = 1'b1;
               off_ctrl.tick = 1'b1;
               if (out_ms_ff != 16'hFFFF) begin
                  out_ms_in = out_ms_ff + 16'd1;
               end
            end
            dbrm_pkg::CMD_SAMPLE, dbrm_pkg::CMD_PAIR: begin
               // A plain sample write is dropped in manual mode; a pair write
               // always goes through.
               if (cmd == dbrm_pkg::CMD_PAIR || !manual_ff) begin
                  if (io_kind_ff == dbrm_pkg::KIND_INPUT ||
                      io_kind_ff == dbrm_pkg::KIND_HOLDING) begin
                     init_in = 1'b1;
                     if (!within_band(req_value_in, measured_ff, deadband_ff)) begin
                        if (is_on(measured_ff) && !is_on(req_value_in)) begin
                           // Falling edge: bank the on seconds, restart off.
                           off_ctrl.restart = 1'b1;
                           run_in = run_sum[32] ? 32'hFFFF_FFFF : run_sum[31:0];
                        end else if (!is_on(measured_ff) && is_on(req_value_in)) begin
                           on_ctrl.restart = 1'b1;
                        end
                        measured_in = req_value_in;
                        changed_in  = 1'b1;
                     end
                  end else if (io_kind_ff == dbrm_pkg::KIND_OUTPUT) begin
                     commanded_in = (cmd == dbrm_pkg::CMD_PAIR) ? req_value_out
                                                                : req_value_in;
                  end
               end
            end
            dbrm_pkg::CMD_POLL: begin
               if (io_kind_ff == dbrm_pkg::KIND_OUTPUT &&
                   !within_band(measured_ff, commanded_ff, deadband_ff) &&
                   out_ms_ff >= interval_ff) begin
                  out_ms_in = '0;
                  due_in    = 1'b1;
               end
            end
            dbrm_pkg::CMD_CLEAR: begin
               changed_in = 1'b0;
            end
            default: begin
               // Unused command codes leave the point untouched.
            end
         endcase
      end

      // The user must write configuration only while no request is in flight; the block does not enforce it.
      if (csr_write_en) begin
         case (csr_index)
            dbrm_pkg::CSR_IO_KIND:      io_kind_in  = csr_write_data[1:0];
            dbrm_pkg::CSR_MANUAL_MODE: begin
               manual_in = csr_write_data[0];
               if (csr_write_data[0]) begin
                  init_in = 1'b1;
               end
            end
            dbrm_pkg::CSR_DEADBAND:     deadband_in = csr_write_data;
            dbrm_pkg::CSR_OUT_INTERVAL: interval_in = csr_write_data[15:0];
            default: begin
               // Writes past the last register are ignored.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         io_kind_ff   <= dbrm_pkg::IO_KIND_RESET;
         manual_ff    <= 1'b0;
         deadband_ff  <= dbrm_pkg::DEADBAND_RESET;
         interval_ff  <= dbrm_pkg::OUT_INTERVAL_RESET;
         measured_ff  <= '0;
         commanded_ff <= '0;
         init_ff      <= 1'b0;
         changed_ff   <= 1'b0;
         out_ms_ff    <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         due_ff       <= 1'b0;
      end else begin
         io_kind_ff   <= io_kind_in;
         manual_ff    <= manual_in;
         deadband_ff  <= deadband_in;
         interval_ff  <= interval_in;
         measured_ff  <= measured_in;
         commanded_ff <= commanded_in;
         init_ff      <= init_in;
         changed_ff   <= changed_in;
         out_ms_ff    <= out_ms_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         due_ff       <= due_in;
      end
   end

   // The on timer restarts on a rising edge and the off timer on a falling
   // edge; both count every tick and saturate at 2^32-1 ms.
   dbrm_run_timer u_on_timer (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (on_ctrl),
      .seconds (on_sec)
   );

   dbrm_run_timer u_off_timer (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (off_ctrl),
      .seconds (off_sec)
   );

   // The result reflects the state right after its request was applied.
   // Apart from configuration writes, the state cannot move while a result waits, because
   // no request is taken until the result is gone, so the fields are read straight off the state.
   assign now_on = is_on(measured_ff);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_measured_value = measured_ff;
   assign rsp_command_value  = commanded_ff;
   assign rsp_on_seconds     = (init_ff && now_on) ? on_sec : '0;
   assign rsp_off_seconds    = (init_ff && !now_on) ? off_sec : '0;
   assign rt_sum             = {1'b0, run_ff} + {10'd0, rsp_on_seconds};
   assign rsp_runtime_seconds = rt_sum[32] ? 32'hFFFF_FFFF : rt_sum[31:0];
   assign rsp_changed        = changed_ff;
   assign rsp_initialized    = init_ff;
   assign rsp_output_due     = due_ff;

endmodule
`default_nettype wire

// ===== sv/dbrm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dbrm_checker
// Port-level checks for the deadband point runtime meter, bound to the top.
// ----------------------------------------------------------------------------
module dbrm_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [31:0] rsp_measured_value,
   input wire logic [22:0]        rsp_on_seconds,
   input wire logic [22:0]        rsp_off_seconds,
   input wire logic [31:0]        rsp_runtime_seconds,
   input wire logic               rsp_initialized
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_measured_value))
      else $error("stalled result changed");

   // No new request is taken while a result is stalled.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken over a stalled result");

   // A point is never on and off at once.
   a_on_off_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_on_seconds != 23'd0 |-> rsp_off_seconds == 23'd0)
      else $error("on and off seconds both nonzero");

   // Timers only report for an initialized point.
   a_timer_init: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_on_seconds != 23'd0 || rsp_off_seconds != 23'd0)
      |-> rsp_initialized)
      else $error("timer reported before initialization");

   // Run time includes the current on seconds.
   a_runtime_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_runtime_seconds >= {9'd0, rsp_on_seconds})
      else $error("runtime below on seconds");

endmodule

bind deadband_point_runtime_meter_top dbrm_checker u_dbrm_checker (.*);
`default_nettype wire
